/* hw/rtl/weekly_event_timer_switch_macros.svh */
// ----------------------------------------------------------------------------
// Weekly event timer switch assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEEKLY_EVENT_TIMER_SWITCH_MACROS_SVH
`define WEEKLY_EVENT_TIMER_SWITCH_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define WETS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weekly_event_timer_switch: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define WETS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weekly_event_timer_switch: next-cycle check failed");

`endif

/* hw/rtl/wets_pkg.sv */
// ----------------------------------------------------------------------------
// Weekly event timer switch package
// Beat types, command and action codes, time constants and sequencer states.
// ----------------------------------------------------------------------------
package wets_pkg;

	localparam int POS_W = 14;

	localparam logic [4:0]       HOUR_PER_DAY = 5'd24;
	localparam logic [5:0]       MIN_PER_HOUR = 6'd60;
	localparam logic [2:0]       DAY_PER_WEEK = 3'd7;
	localparam logic [POS_W-1:0] MIN_PER_DAY  = 14'd1440;
	localparam logic [POS_W-1:0] MIN_PER_WEEK = 14'd10080;

	typedef enum logic [1:0] {
		CMD_TIME  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_STOP  = 2'd2
	} command_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_ON        = 3'd1,
		ACT_OFF       = 3'd2,
		ACT_TOGGLE    = 3'd3,
		ACT_PULSE_OFF = 3'd4,
		ACT_PULSE_ON  = 3'd5
	} action_t;

	typedef struct packed {
		logic [1:0] command;
		logic       time_valid;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
		logic [2:0] now_weekday;
		logic [3:0] entry_index;
		logic [6:0] entry_day_mask;
		logic [4:0] entry_hour;
		logic [5:0] entry_minute;
		logic [2:0] entry_action;
	} cmd_t;

	typedef struct packed {
		logic [2:0] fired_action;
		logic       relay_on;
		logic       pulsed;
	} res_t;

	typedef struct packed {
		logic [6:0] day_mask;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [2:0] action;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SPAN,
		ST_RD,
		ST_EM,
		ST_DAY,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/weekly_event_timer_switch.sv */
// ----------------------------------------------------------------------------
// Weekly event timer switch
// Event table, minute walk over elapsed time and relay control.
// ----------------------------------------------------------------------------
// Write, stop and non-walking time beats leave the sequencer idle. A time
// beat that moves a synchronised clock starts a walk in which one offset
// adder/comparator visits every entry: it reads the table, forms the entry's
// first offset from the recorded time and steps it through the seven
// weekdays, keeping the latest match in the elapsed span. The table valid
// bits clear at reset, so no clearing pass is needed. A finished result waits
// in an output register; the block takes the next beat while it waits, and a
// later walk that ends before that result is taken holds in its done state
// until the output register frees.
`include "weekly_event_timer_switch_macros.svh"

module weekly_event_timer_switch #(
	parameter int MAX_EVENTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  wets_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output wets_pkg::res_t res
);
	import wets_pkg::*;

	localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam logic [6:0]    NUM_EV  = 7'(MAX_EVENTS);
	localparam logic [IW-1:0] LAST_EV = IW'(MAX_EVENTS - 1);

	state_t state_q, state_d;

	entry_t              mem [MAX_EVENTS];
	logic [MAX_EVENTS-1:0] vld_q;
	entry_t              rd_q;
	logic                rd_vld_q;

	logic [4:0] last_hour_q, now_hour_q;
	logic [5:0] last_min_q, now_min_q;
	logic [2:0] last_wd_q, now_wd_q;
	logic       synced_q, relay_q;

	logic [POS_W-1:0] lp_q, np_q, span_q, off_q, best_q;
	logic [2:0]       act_q;
	logic             elig_q;
	logic [IW-1:0]    ent_q;
	logic [2:0]       day_q;

	logic res_valid_q;
	res_t res_q;

	logic       accept, time_ok, same_time, start_walk;
	logic [6:0] idx_ext;
	logic [IW-1:0] wr_idx;
	logic [2:0] wr_act;
	logic       out_free, finish;

	logic [POS_W:0]   span_diff, em_diff, step_sum;
	logic [POS_W-1:0] em_pos, span_val, em_off, step_off;
	logic             match;
	logic             relay_new;
	logic             res_pulse_act;

	assign accept  = cmd_valid && cmd_ready;
	assign time_ok = cmd.time_valid && (cmd.now_hour < HOUR_PER_DAY)
		&& (cmd.now_minute < MIN_PER_HOUR) && (cmd.now_weekday < DAY_PER_WEEK);
	assign same_time = (cmd.now_hour == last_hour_q) && (cmd.now_minute == last_min_q)
		&& (cmd.now_weekday == last_wd_q);
	assign start_walk = accept && (cmd.command == CMD_TIME) && time_ok && synced_q && !same_time;

	assign idx_ext = {3'b000, cmd.entry_index};
	assign wr_idx  = idx_ext[IW-1:0];
	assign wr_act  = (cmd.entry_action > ACT_PULSE_ON) ? ACT_NONE : cmd.entry_action;

	assign out_free = !res_valid_q || res_ready;
	assign finish   = (state_q == ST_DONE) && out_free;

	// span of the walk, wrapped into the week
	assign span_diff = {1'b0, np_q} - {1'b0, lp_q};
	assign span_val  = span_diff[POS_W] ? (span_diff[POS_W-1:0] + MIN_PER_WEEK)
		: span_diff[POS_W-1:0];

	// offset of the entry's day-0 firing from the recorded time
	assign em_pos  = POS_W'(rd_q.hour) * POS_W'(MIN_PER_HOUR) + POS_W'(rd_q.minute);
	assign em_diff = {1'b0, em_pos} - {1'b0, lp_q};
	assign em_off  = em_diff[POS_W] ? (em_diff[POS_W-1:0] + MIN_PER_WEEK)
		: em_diff[POS_W-1:0];

	// advance one day, wrapping the week
	assign step_sum = {1'b0, off_q} + {1'b0, MIN_PER_DAY};
	assign step_off = (step_sum >= {1'b0, MIN_PER_WEEK})
		? POS_W'(step_sum - {1'b0, MIN_PER_WEEK}) : step_sum[POS_W-1:0];

	assign match = elig_q && rd_q.day_mask[day_q] && (off_q != '0)
		&& (off_q <= span_q) && (off_q >= best_q);

	assign res_pulse_act = (res.fired_action == ACT_PULSE_OFF)
		|| (res.fired_action == ACT_PULSE_ON);

	always_comb begin
		unique case (act_q)
			ACT_ON, ACT_PULSE_OFF: relay_new = 1'b1;
			ACT_OFF, ACT_PULSE_ON: relay_new = 1'b0;
			ACT_TOGGLE:            relay_new = !relay_q;
			default:               relay_new = relay_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start_walk) state_d = ST_PREP;
			ST_PREP: state_d = ST_SPAN;
			ST_SPAN: state_d = ST_RD;
			ST_RD:   state_d = ST_EM;
			ST_EM:   state_d = ST_DAY;
			ST_DAY: begin
				if (day_q == DAY_PER_WEEK - 3'd1) begin
					state_d = (ent_q == LAST_EV) ? ST_DONE : ST_RD;
				end
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
		res_valid = res_valid_q;
		res       = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			synced_q    <= 1'b0;
			relay_q     <= 1'b0;
			last_hour_q <= '0;
			last_min_q  <= '0;
			last_wd_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (cmd.command)
					CMD_WRITE: begin
						if (idx_ext < NUM_EV) vld_q[wr_idx] <= 1'b1;
					end
					CMD_STOP: begin
						synced_q    <= 1'b0;
						last_hour_q <= '0;
						last_min_q  <= '0;
						last_wd_q   <= '0;
					end
					CMD_TIME: begin
						// first valid time only records it
						if (time_ok && !synced_q) begin
							synced_q    <= 1'b1;
							last_hour_q <= cmd.now_hour;
							last_min_q  <= cmd.now_minute;
							last_wd_q   <= cmd.now_weekday;
						end
					end
					default: ;
				endcase
			end
			if (finish) begin
				relay_q     <= relay_new;
				last_hour_q <= now_hour_q;
				last_min_q  <= now_min_q;
				last_wd_q   <= now_wd_q;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (accept && (cmd.command == CMD_WRITE) && (idx_ext < NUM_EV)) begin
			mem[wr_idx] <= '{day_mask: cmd.entry_day_mask, hour: cmd.entry_hour,
				minute: cmd.entry_minute, action: wr_act};
		end
		if (state_q == ST_RD) begin
			rd_q     <= mem[ent_q];
			rd_vld_q <= vld_q[ent_q];
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (start_walk) begin
			now_hour_q <= cmd.now_hour;
			now_min_q  <= cmd.now_minute;
			now_wd_q   <= cmd.now_weekday;
		end
		unique case (state_q)
			ST_PREP: begin
				lp_q <= POS_W'(last_wd_q) * MIN_PER_DAY
					+ POS_W'(last_hour_q) * POS_W'(MIN_PER_HOUR) + POS_W'(last_min_q);
				np_q <= POS_W'(now_wd_q) * MIN_PER_DAY
					+ POS_W'(now_hour_q) * POS_W'(MIN_PER_HOUR) + POS_W'(now_min_q);
			end
			ST_SPAN: begin
				span_q <= span_val;
				best_q <= '0;
				act_q  <= ACT_NONE;
				ent_q  <= '0;
			end
			ST_EM: begin
				off_q  <= em_off;
				day_q  <= '0;
				elig_q <= rd_vld_q && (rd_q.action != ACT_NONE)
					&& (rd_q.hour < HOUR_PER_DAY) && (rd_q.minute < MIN_PER_HOUR);
			end
			ST_DAY: begin
				// keep the latest match; later entries win ties
				if (match) begin
					best_q <= off_q;
					act_q  <= rd_q.action;
				end
				off_q <= step_off;
				day_q <= day_q + 3'd1;
				if (day_q == DAY_PER_WEEK - 3'd1) ent_q <= ent_q + IW'(1);
			end
			default: ;
		endcase
		if (finish) begin
			res_q.fired_action <= act_q;
			res_q.relay_on     <= relay_new;
			res_q.pulsed       <= (act_q == ACT_PULSE_OFF) || (act_q == ACT_PULSE_ON);
		end
	end

	`WETS_ASSERT_NEXT(a_done_emits, (state_q == ST_DONE) && out_free, res_valid)
	`WETS_ASSERT_SAME(a_best_in_span, state_q == ST_DAY, best_q <= span_q)
	`WETS_ASSERT_SAME(a_pulse_flag, res_valid, res.pulsed == res_pulse_act)
	`WETS_ASSERT_SAME(a_pulse_off_level, res_valid && (res.fired_action == ACT_PULSE_OFF), res.relay_on)

endmodule

/* tb/sv/weekly_event_timer_switch_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekly event timer switch testbench
// Drives write, stop and time beats through the command channel, predicts
// relay results from a local copy of the event table and the recorded time
// where a directed row gives none of its own, and checks each result beat
// field by field. A short directed table covers the edge cases; bursty random
// traffic with a stalling receiver follows.
// ----------------------------------------------------------------------------
module weekly_event_timer_switch_tb;
	import wets_pkg::*;

	localparam int          MAX_EVENTS   = 16;
	localparam int          TARGET_BEATS = 1350;
	localparam int          DRAIN_CYCLES = 200;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [2:0]  ACT_BAD      = 3'd7;
	localparam int unsigned WEEK_LEN     = MIN_PER_WEEK;

	typedef struct {
		cmd_t beat;
		bit   typed;
		bit   has_res;
		res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	// local copy of the schedule state
	entry_t     sched [MAX_EVENTS];
	logic [4:0] rec_hour;
	logic [5:0] rec_minute;
	logic [2:0] rec_day;
	bit         is_synced;
	bit         relay;

	res_t        pending_relay_q [$];
	dir_row_t    dir_rows [$];
	int unsigned mismatch_cnt = 0;
	int unsigned res_seen = 0;
	int unsigned burst_left = 0;
	int unsigned wall_pos = 0;
	int unsigned rx_left = 0;
	bit          rx_on = 1'b0;

	weekly_event_timer_switch #(
		.MAX_EVENTS(MAX_EVENTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#30_000_000;
		$display("FAIL weekly_event_timer_switch");
		$finish;
	end

	function automatic int unsigned week_minute(int unsigned d, int unsigned h, int unsigned m);
		return d * MIN_PER_DAY + h * MIN_PER_HOUR + m;
	endfunction

	function automatic void split_pos(input int unsigned pos, output logic [2:0] d,
			output logic [4:0] h, output logic [5:0] m);
		d = 3'(pos / MIN_PER_DAY);
		h = 5'((pos % MIN_PER_DAY) / MIN_PER_HOUR);
		m = 6'(pos % MIN_PER_HOUR);
	endfunction

	function automatic void reset_schedule();
		foreach (sched[i])
			sched[i] = '0;
		rec_hour = '0;
		rec_minute = '0;
		rec_day = '0;
		is_synced = 1'b0;
		relay = 1'b0;
	endfunction

	// Apply one accepted beat to the schedule; report the relay result it causes.
	function automatic void advance_schedule(input cmd_t c, output bit fired, output res_t r);
		int unsigned lp;
		int unsigned np;
		int unsigned span;
		int unsigned off;
		int unsigned best_off;
		logic [2:0]  act;
		fired = 1'b0;
		r = '0;
		case (c.command)
			CMD_WRITE: begin
				if (c.entry_index < MAX_EVENTS) begin
					sched[c.entry_index].day_mask = c.entry_day_mask;
					sched[c.entry_index].hour = c.entry_hour;
					sched[c.entry_index].minute = c.entry_minute;
					sched[c.entry_index].action =
						(c.entry_action > ACT_PULSE_ON) ? ACT_NONE : c.entry_action;
				end
			end
			CMD_STOP: begin
				is_synced = 1'b0;
				rec_hour = '0;
				rec_minute = '0;
				rec_day = '0;
			end
			CMD_TIME: begin
				if (c.time_valid && c.now_hour < HOUR_PER_DAY && c.now_minute < MIN_PER_HOUR
						&& c.now_weekday < DAY_PER_WEEK) begin
					if (!is_synced) begin
						is_synced = 1'b1;
						rec_hour = c.now_hour;
						rec_minute = c.now_minute;
						rec_day = c.now_weekday;
					end else begin
						lp = week_minute(rec_day, rec_hour, rec_minute);
						np = week_minute(c.now_weekday, c.now_hour, c.now_minute);
						if (lp != np) begin
							span = (np + WEEK_LEN - lp) % WEEK_LEN;
							best_off = 0;
							act = ACT_NONE;
							// later minute wins; within a minute the higher slot wins
							for (int i = 0; i < MAX_EVENTS; i++) begin
								if (sched[i].action == ACT_NONE || sched[i].hour >= HOUR_PER_DAY
										|| sched[i].minute >= MIN_PER_HOUR)
									continue;
								for (int d = 0; d < DAY_PER_WEEK; d++) begin
									if (!sched[i].day_mask[d])
										continue;
									off = (week_minute(d, sched[i].hour, sched[i].minute)
										+ WEEK_LEN - lp) % WEEK_LEN;
									if (off != 0 && off <= span && off >= best_off) begin
										best_off = off;
										act = sched[i].action;
									end
								end
							end
							case (act)
								ACT_ON:        relay = 1'b1;
								ACT_OFF:       relay = 1'b0;
								ACT_TOGGLE:    relay = !relay;
								ACT_PULSE_OFF: relay = 1'b1;
								ACT_PULSE_ON:  relay = 1'b0;
								default: ;
							endcase
							rec_hour = c.now_hour;
							rec_minute = c.now_minute;
							rec_day = c.now_weekday;
							fired = 1'b1;
							r.fired_action = act;
							r.relay_on = relay;
							r.pulsed = (act == ACT_PULSE_OFF || act == ACT_PULSE_ON);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic cmd_t plain_beat(logic [1:0] op);
		cmd_t c;
		c = '0;
		c.command = op;
		return c;
	endfunction

	function automatic cmd_t time_beat(logic v, logic [2:0] d, logic [4:0] h, logic [5:0] m);
		cmd_t c;
		c = plain_beat(CMD_TIME);
		c.time_valid = v;
		c.now_weekday = d;
		c.now_hour = h;
		c.now_minute = m;
		return c;
	endfunction

	function automatic cmd_t write_beat(logic [3:0] idx, logic [6:0] mask, logic [4:0] h,
			logic [5:0] m, logic [2:0] act);
		cmd_t c;
		c = plain_beat(CMD_WRITE);
		c.entry_index = idx;
		c.entry_day_mask = mask;
		c.entry_hour = h;
		c.entry_minute = m;
		c.entry_action = act;
		return c;
	endfunction

	function automatic void add_row(cmd_t c, bit typed, bit has_res, res_t r);
		dir_row_t row;
		row.beat = c;
		row.typed = typed;
		row.has_res = has_res;
		row.res = r;
		dir_rows.push_back(row);
	endfunction

	// Hold the beat until accepted, then predict what it causes.
	task automatic push_beat(input cmd_t c, output bit fired, output res_t r);
		cmd <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		advance_schedule(c, fired, r);
	endtask

	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 10);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 16);
		end
	endtask

	task automatic wait_for_results();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_relay_q.size() != 0);
	endtask

	// Mostly well-formed traffic around a running wall clock; the rest is noise.
	task automatic random_beat(output cmd_t c);
		logic [63:0] rnd;
		int unsigned pick;
		int unsigned k;
		logic [2:0]  td;
		logic [4:0]  th;
		logic [5:0]  tm;
		rnd = {$urandom, $urandom};
		c = rnd[$bits(cmd_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, WEEK_LEN - 1) : $urandom_range(0, 6);
			wall_pos = (wall_pos + k) % WEEK_LEN;
			c.command = CMD_TIME;
			c.time_valid = 1'b1;
			split_pos(wall_pos, c.now_weekday, c.now_hour, c.now_minute);
		end else if (pick < 78) begin
			c.command = CMD_WRITE;
			split_pos((wall_pos + $urandom_range(1, 10)) % WEEK_LEN, td, th, tm);
			if ($urandom_range(0, 3) != 0) begin
				c.entry_hour = th;
				c.entry_minute = tm;
				if ($urandom_range(0, 1) != 0)
					c.entry_day_mask[td] = 1'b1;
			end
			if ($urandom_range(0, 99) < 85)
				c.entry_action = 3'($urandom_range(ACT_ON, ACT_PULSE_ON));
		end else if (pick < 82) begin
			c.command = CMD_STOP;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					c.command = CMD_TIME;
					c.time_valid = 1'b0;
				end
				1: begin
					c.command = CMD_TIME;
					c.time_valid = 1'b1;
					case ($urandom_range(0, 2))
						0: c.now_hour = 5'($urandom_range(HOUR_PER_DAY, 31));
						1: c.now_minute = 6'($urandom_range(MIN_PER_HOUR, 63));
						default: c.now_weekday = DAY_PER_WEEK;
					endcase
				end
				2: c.command = CMD_UNUSED;
				default: begin
					// jump the wall clock anywhere in the week
					wall_pos = $urandom_range(0, WEEK_LEN - 1);
					c.command = CMD_TIME;
					c.time_valid = 1'b1;
					split_pos(wall_pos, c.now_weekday, c.now_hour, c.now_minute);
				end
			endcase
		end
	endtask

	// Receiver: alternate ready runs and stalls of random length.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_on = !rx_on;
				rx_left = rx_on ? (($urandom_range(0, 4) == 0) ? 300 : $urandom_range(1, 30))
					: $urandom_range(1, 40);
			end else begin
				rx_left--;
			end
			res_ready <= rx_on;
			if (res_valid && res_ready) begin
				res_seen++;
				if (pending_relay_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("relay beat %0d: unexpected, action %0d relay %0b pulse %0b",
							res_seen, res.fired_action, res.relay_on, res.pulsed);
				end else begin
					if (res.fired_action !== pending_relay_q[0].fired_action
							|| res.relay_on !== pending_relay_q[0].relay_on
							|| res.pulsed !== pending_relay_q[0].pulsed) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"relay beat %0d: expected action %0d relay %0b pulse %0b,",
								" got action %0d relay %0b pulse %0b"}, res_seen,
								pending_relay_q[0].fired_action, pending_relay_q[0].relay_on,
								pending_relay_q[0].pulsed, res.fired_action, res.relay_on,
								res.pulsed);
					end
					void'(pending_relay_q.pop_front());
				end
			end
		end
	end

	initial begin
		cmd_t        c;
		bit          fired;
		bit          paused;
		res_t        r;
		int unsigned beat_cnt;
		reset_schedule();
		// before sync: unknown clock, out-of-range times
		add_row(time_beat(1'b0, 3'd1, 5'd5, 6'd5), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd0, 5'd24, 6'd0), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd60), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd7, 5'd0, 6'd0), 1, 0, '0);
		// first valid time syncs, repeated time does nothing, no entries matched
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd0), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd0), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd1), 1, 1, res_t'{ACT_NONE, 1'b0, 1'b0});
		add_row(write_beat(4'd0, 7'h7F, 5'd0, 6'd2, ACT_ON), 1, 0, '0);
		add_row(write_beat(4'd15, 7'h01, 5'd0, 6'd3, ACT_PULSE_OFF), 1, 0, '0);
		// bad action code stores as none; out-of-range time never matches
		add_row(write_beat(4'd1, 7'h7F, 5'd0, 6'd4, ACT_BAD), 1, 0, '0);
		add_row(write_beat(4'd2, 7'h7F, 5'd31, 6'd63, ACT_TOGGLE), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd2), 1, 1, res_t'{ACT_ON, 1'b1, 1'b0});
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd3), 1, 1, res_t'{ACT_PULSE_OFF, 1'b1, 1'b1});
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd5), 1, 1, res_t'{ACT_NONE, 1'b1, 1'b0});
		add_row(write_beat(4'd3, 7'h7F, 5'd23, 6'd59, ACT_TOGGLE), 1, 0, '0);
		add_row(write_beat(4'd4, 7'h40, 5'd23, 6'd59, ACT_PULSE_ON), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd6, 5'd23, 6'd59), 0, 0, '0);
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd0), 0, 0, '0);
		add_row(plain_beat(CMD_STOP), 1, 0, '0);
		add_row(plain_beat(CMD_UNUSED), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd1, 5'd12, 6'd30), 1, 0, '0);
		add_row(write_beat(4'd5, 7'h00, 5'd12, 6'd31, ACT_ON), 1, 0, '0);
		add_row(write_beat(4'd6, 7'h7F, 5'd0, 6'd0, ACT_OFF), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd1, 5'd31, 6'd63), 1, 0, '0);
		// walk back round the week
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd3), 0, 0, '0);
		add_row(write_beat(4'd7, 7'h7F, 5'd0, 6'd4, ACT_TOGGLE), 1, 0, '0);
		add_row(time_beat(1'b1, 3'd0, 5'd0, 6'd4), 0, 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			push_beat(dir_rows[i].beat, fired, r);
			if (dir_rows[i].typed) begin
				if (dir_rows[i].has_res)
					pending_relay_q.push_back(dir_rows[i].res);
			end else if (fired) begin
				pending_relay_q.push_back(r);
			end
			pace_sender();
		end
		wait_for_results();

		beat_cnt = 0;
		paused = 1'b0;
		wall_pos = $urandom_range(0, WEEK_LEN - 1);
		while (beat_cnt < TARGET_BEATS) begin
			random_beat(c);
			push_beat(c, fired, r);
			if (fired)
				pending_relay_q.push_back(r);
			beat_cnt++;
			if (!paused && beat_cnt >= TARGET_BEATS / 2) begin
				paused = 1'b1;
				wait_for_results();
			end else begin
				pace_sender();
			end
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_relay_q.size() == 0)
			$display("PASS weekly_event_timer_switch");
		else
			$display("FAIL weekly_event_timer_switch");
		$finish;
	end

endmodule
